// ===== design/udiv_pkg.sv =====
// shared types and constants for the pipelined unsigned divider
// no dependencies; imported by udiv_step and unsigned_divide_64_by_64
`timescale 1ns / 1ps
`default_nettype none

package udiv_pkg;

  // width of the interface fields
  localparam int unsigned FIELD_WIDTH = 64;
  // operand width actually divided (8 to 64); upper field bits are ignored
  localparam int unsigned DATA_WIDTH  = 64;
  // input register, one stage per quotient bit, output register
  localparam int unsigned LATENCY     = DATA_WIDTH + 2;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] dividend;
    logic [FIELD_WIDTH-1:0] divisor;
  } operands_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] quotient;
    logic [FIELD_WIDTH-1:0] remainder;
  } result_t;

  // state carried between pipeline stages
  typedef struct packed {
    logic                  div_zero;  // divisor was zero
    logic [DATA_WIDTH-1:0] rem;       // partial remainder
    logic [DATA_WIDTH-1:0] dq;        // unused dividend bits on top, quotient bits below
    logic [DATA_WIDTH-1:0] divisor;
  } step_t;

endpackage

`default_nettype wire

// ===== design/udiv_step.sv =====
// one restoring division step with its pipeline register
// depends on udiv_pkg for step_t and DATA_WIDTH
`timescale 1ns / 1ps
`default_nettype none

module udiv_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  udiv_pkg::step_t      step_i,
  output logic                 valid_o,
  output udiv_pkg::step_t      step_o
);
  import udiv_pkg::*;

  logic                  carry;
  logic [DATA_WIDTH-1:0] shifted;
  logic                  borrow;
  logic [DATA_WIDTH-1:0] diff;
  logic                  fits;
  step_t                 step_d;
  step_t                 step_q;
  logic                  valid_q;

  always_comb begin
    // bit shifted out of the remainder acts as a carry into the compare
    carry            = step_i.rem[DATA_WIDTH-1];
    shifted          = {step_i.rem[DATA_WIDTH-2:0], step_i.dq[DATA_WIDTH-1]};
    {borrow, diff}   = {1'b0, shifted} - {1'b0, step_i.divisor};
    fits             = carry | ~borrow;
    step_d           = step_i;
    step_d.rem       = fits ? diff : shifted;
    step_d.dq        = {step_i.dq[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
  end

  assign valid_o = valid_q;
  assign step_o  = step_q;

endmodule

`default_nettype wire

// ===== design/unsigned_divide_64_by_64.sv =====
// top level of the pipelined unsigned 64-by-64 restoring divider
// depends on udiv_pkg and udiv_step
`timescale 1ns / 1ps
`default_nettype none

// Unsigned divider: quotient and remainder of dividend by divisor. A transfer
// is taken on every clock edge where start is high; busy is always low, so a
// new operation may be issued in every cycle. Each result appears on result_o
// for one cycle, with result_valid_o high, after passing through one input
// register, one pipeline stage per quotient bit (each a single DATA_WIDTH-bit
// subtract and select), and one output register. Results leave in issue
// order and cannot be held off. A zero divisor gives quotient zero and
// remainder equal to the dividend, with no error indication.
module unsigned_divide_64_by_64 (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  udiv_pkg::operands_t       operands_i,
  output logic                      result_valid_o,
  output udiv_pkg::result_t         result_o
);
  import udiv_pkg::*;

  // pipeline never stalls
  assign busy = 1'b0;

  // stage 0 is the input register; stage DATA_WIDTH is the last step output
  logic  stage_valid [DATA_WIDTH+1];
  step_t stage_data  [DATA_WIDTH+1];

  // input register
  logic  in_valid_q;
  step_t in_step_d;
  step_t in_step_q;

  always_comb begin
    in_step_d.div_zero = (operands_i.divisor[DATA_WIDTH-1:0] == '0);
    in_step_d.rem      = '0;
    in_step_d.dq       = operands_i.dividend[DATA_WIDTH-1:0];
    in_step_d.divisor  = operands_i.divisor[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_step_q <= in_step_d;
  end

  assign stage_valid[0] = in_valid_q;
  assign stage_data[0]  = in_step_q;

  // one quotient bit per stage, most significant first
  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
    udiv_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .step_i  (stage_data[g]),
      .valid_o (stage_valid[g+1]),
      .step_o  (stage_data[g+1])
    );
  end

  // output register, with the zero-divisor override
  logic    out_valid_q;
  result_t out_res_d;
  result_t out_res_q;
  step_t   last;

  always_comb begin
    last = stage_data[DATA_WIDTH];
    if (last.div_zero) begin
      // steps ran with divisor zero: remainder comes back as the dividend,
      // quotient bits all set, so force the quotient to zero
      out_res_d.quotient  = '0;
      out_res_d.remainder = FIELD_WIDTH'(last.rem);
    end else begin
      out_res_d.quotient  = FIELD_WIDTH'(last.dq);
      out_res_d.remainder = FIELD_WIDTH'(last.rem);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= stage_valid[DATA_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_res_q;

  // every accepted transfer comes out as a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("result missing after accepted transfer");

  // no result without a matching earlier transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LATENCY))
    else $error("result without matching transfer");

  // zero divisor: quotient zero, remainder equals dividend
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ($past(operands_i.divisor[DATA_WIDTH-1:0], LATENCY) == '0))
    |-> (result_o.quotient == '0) &&
        (result_o.remainder[DATA_WIDTH-1:0] ==
         $past(operands_i.dividend[DATA_WIDTH-1:0], LATENCY)))
    else $error("zero divisor result wrong");

  // remainder stays below a nonzero divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ($past(operands_i.divisor[DATA_WIDTH-1:0], LATENCY) != '0))
    |-> (result_o.remainder[DATA_WIDTH-1:0] <
         $past(operands_i.divisor[DATA_WIDTH-1:0], LATENCY)))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire
